// ----- sv/wgm_pkg.sv -----
// ============================================================================
// wgm_pkg
// Shared types and constants for the wildcard glob matcher.
// ============================================================================
package wgm_pkg;

    // Register capacity of the pattern registers, in bytes.
    localparam int unsigned REG_BYTES = 16;

    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned LEN_W       = 5;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Input action codes.
    localparam logic ACTION_CHAR = 1'b0;
    localparam logic ACTION_EOS  = 1'b1;

    // Pattern wildcards.
    localparam logic [7:0] CHAR_ANY  = 8'h3F;
    localparam logic [7:0] CHAR_STAR = 8'h2A;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic step;    // a text character beat is accepted with no register write this cycle
        logic fresh;   // the held state is the start state
    } cell_ctl_t;

endpackage

// ----- sv/wgm_if.sv -----
// ============================================================================
// wgm_in_if / wgm_out_if
// Valid/ready channels for the text beats and the match results.
// ============================================================================
interface wgm_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] text_char;

    modport source (output valid, output action, output text_char, input ready);
    modport sink   (input valid, input action, input text_char, output ready);
endinterface

interface wgm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

// ----- sv/wgm_cell.sv -----
// ============================================================================
// wgm_cell
// One pattern position: holds its active bit, works out the bit for the next
// character and passes advance and star-closure terms to its neighbour.
// ============================================================================
module wgm_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  wgm_pkg::cell_ctl_t ctl,
    input  logic [7:0]         pat_byte,
    input  logic               in_use,
    input  logic [7:0]         text_char,
    input  logic               start_in,
    input  logic               adv_in,
    input  logic               carry_in,
    output logic               start_out,
    output logic               adv_out,
    output logic               carry_out,
    output logic               cur_bit
);
    import wgm_pkg::*;

    logic act_reg;
    logic act_next;
    logic is_star;
    logic hit;

    assign is_star = in_use && (pat_byte == CHAR_STAR);
    assign hit     = (pat_byte == CHAR_ANY) || (pat_byte == text_char);

    // The start state is the closure of position zero through leading stars.
    assign start_out = start_in && is_star;
    assign cur_bit   = ctl.fresh ? start_in : act_reg;

    assign adv_out   = cur_bit && in_use && !is_star && hit;

    // A star keeps itself active and, once active, passes activity onward.
    assign act_next  = (cur_bit && is_star) || adv_in || carry_in;
    assign carry_out = act_next && is_star;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            act_reg <= act_next;
        end
    end

endmodule

// ----- sv/wildcard_glob_matcher.sv -----
// ============================================================================
// wildcard_glob_matcher
// Streams text beats against a configured glob pattern ('?' and '*') and
// reports one match bit for each end-of-string beat.
// ============================================================================
// Throughput: one input beat per cycle, set by the update of the row of
// position cells. The match result is registered in the cycle after its
// end-of-string beat. The input is held only while a result waits.
// Reset: pattern registers and length clear to zero, the position state
// returns to the start state and no result is pending. Any register write
// also restarts the current text.
module wildcard_glob_matcher
#(
    parameter int unsigned PATTERN_MAX = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wgm_pkg::CFG_DATA_W-1:0]   cfg_data,
    wgm_in_if.sink                           text,
    wgm_out_if.source                        result
);
    import wgm_pkg::*;

    localparam int unsigned CELLS = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
    localparam int unsigned POS_W = $clog2(CELLS + 1);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;
    logic                  fresh_reg;
    logic                  fresh_next;
    logic                  last_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  matched_reg;

    logic [2*CFG_DATA_W-1:0] pat_all;
    logic [POS_W-1:0]        eff_len;
    logic                    in_beat;
    logic                    char_beat;
    logic                    eos_beat;
    cell_ctl_t               ctl;

    logic [CELLS:0]   start_chain;
    logic [CELLS:0]   adv_chain;
    logic [CELLS:0]   carry_chain;
    logic [CELLS:0]   cur_vec;
    logic [CELLS-1:0] in_use;

    assign pat_all = {pat_high_reg, pat_low_reg};
    assign eff_len = (pat_len_reg > LEN_W'(CELLS)) ? POS_W'(CELLS) : POS_W'(pat_len_reg);

    assign text.ready = !out_valid_reg || result.ready;
    assign in_beat    = text.valid && text.ready;
    assign char_beat  = in_beat && (text.action == ACTION_CHAR);
    assign eos_beat   = in_beat && (text.action == ACTION_EOS);

    assign ctl.step  = char_beat && !cfg_we;
    assign ctl.fresh = fresh_reg;

    assign start_chain[0] = 1'b1;
    assign adv_chain[0]   = 1'b0;
    assign carry_chain[0] = 1'b0;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        assign in_use[i] = (POS_W'(i) < eff_len);

        wgm_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .pat_byte  (pat_all[8*i +: 8]),
            .in_use    (in_use[i]),
            .text_char (text.text_char),
            .start_in  (start_chain[i]),
            .adv_in    (adv_chain[i]),
            .carry_in  (carry_chain[i]),
            .start_out (start_chain[i+1]),
            .adv_out   (adv_chain[i+1]),
            .carry_out (carry_chain[i+1]),
            .cur_bit   (cur_vec[i])
        );
    end

    // The position past the last cell has no byte of its own to test.
    assign cur_vec[CELLS] = fresh_reg ? start_chain[CELLS] : last_reg;

    always_comb
    begin
        fresh_next = fresh_reg;
        if (cfg_we || eos_beat)
        begin
            fresh_next = 1'b1;
        end
        else if (char_beat)
        begin
            fresh_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (eos_beat)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg   <= '0;
            pat_high_reg  <= '0;
            pat_len_reg   <= '0;
            fresh_reg     <= 1'b1;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
            if (ctl.step)
            begin
                last_reg <= adv_chain[CELLS] || carry_chain[CELLS];
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                    REG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                    REG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[LEN_W-1:0];
                    default:            ;
                endcase
            end
        end
    end

    // Result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (eos_beat)
        begin
            matched_reg <= cur_vec[eff_len];
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.matched = matched_reg;

endmodule
